[hw/rtl/dmbs_pkg.sv]
package dmbs_pkg;

   // Field widths of the transaction ports
   localparam int unsigned COORD_BITS      = 10;
   localparam int unsigned IDX_W           = 6;
   localparam int unsigned CMD_W           = 3;
   localparam int unsigned KEY_W           = 3;
   localparam int unsigned LINK_W          = 24;
   localparam int unsigned ACTION_W        = 64;
   localparam int unsigned PAL_W           = 32;
   localparam int unsigned GEOM_W          = 48;
   localparam int unsigned MAX_BUTTONS_DEF = 36;
   localparam int unsigned PAL_SLOTS       = 3;

   // Squared distance; the far value exceeds any real distance
   localparam int unsigned DIST_W   = 28;
   localparam logic [DIST_W-1:0] FAR_DIST = 28'h8000000;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOAD_BUTTON  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_PALETTE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET_COUNT    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_KEY          = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLICK        = 3'd4;

   // Key codes
   localparam logic [KEY_W-1:0] KEY_LEFT  = 3'd0;
   localparam logic [KEY_W-1:0] KEY_RIGHT = 3'd1;
   localparam logic [KEY_W-1:0] KEY_UP    = 3'd2;
   localparam logic [KEY_W-1:0] KEY_DOWN  = 3'd3;
   localparam logic [KEY_W-1:0] KEY_OK    = 3'd4;

   typedef struct packed {
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] y_end;
   } rect_type;

   typedef struct packed {
      rect_type              rect;
      logic [LINK_W-1:0]     links;
      logic [ACTION_W-1:0]   action;
      logic [1:0]            color;
      logic                  auto_act;
   } entry_type;

   // Unpack the six coordinate bytes, byte 0 in the top bits
   function automatic rect_type unpack_geometry(input logic [GEOM_W-1:0] g);
      rect_type r;
      r.x_start = {g[45:40], g[39:36]};
      r.x_end   = {g[33:32], g[31:24]};
      r.y_start = {g[21:16], g[15:12]};
      r.y_end   = {g[9:8],   g[7:0]};
      return r;
   endfunction

   // Expand the four low palette nibbles into alpha bytes; full nibble gives full alpha
   function automatic logic [PAL_W-1:0] alpha_of(input logic [PAL_W-1:0] pal);
      logic [PAL_W-1:0] r;
      logic [3:0]       n;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         n = pal[4*i +: 4];
         r[8*i +: 8] = (n == 4'hf) ? 8'hff : {n, 4'h0};
      end
      return r;
   endfunction

endpackage

[hw/rtl/dvd_menu_button_select_unit.sv]
// Load button, load palette and set count take effect at acceptance: no result, busy stays low.
// Key: result strobe from ST_KEY_LINK, or from ST_KEY_TGT when the key moves to a linked button.
// Click: result strobe from ST_CLK_DONE once ST_SCAN has walked all N buttons; the
//   button table memory's single read port walks one button per cycle into the distance unit.
// One transaction at a time; busy is high until the result cycle. The receiver cannot stall.
// Reset: current button 1, button count 0; button table and palette undefined until written.
module dvd_menu_button_select_unit #(
   parameter int unsigned MAX_BUTTONS = dmbs_pkg::MAX_BUTTONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [dmbs_pkg::CMD_W-1:0]          req_command,
   input  logic [dmbs_pkg::IDX_W-1:0]          req_index,
   input  logic [dmbs_pkg::GEOM_W-1:0]         req_raw_geometry,
   input  logic [1:0]                          req_color_set,
   input  logic                                req_auto_action,
   input  logic [dmbs_pkg::LINK_W-1:0]         req_links,
   input  logic [dmbs_pkg::ACTION_W-1:0]       req_action_word,
   input  logic [dmbs_pkg::PAL_W-1:0]          req_palette_word,
   input  logic [dmbs_pkg::KEY_W-1:0]          req_key,
   input  logic [dmbs_pkg::COORD_BITS-1:0]     req_pos_x,
   input  logic [dmbs_pkg::COORD_BITS-1:0]     req_pos_y,
   output logic                                rsp_valid,
   output logic                                rsp_execute,
   output logic [dmbs_pkg::ACTION_W-1:0]       rsp_command_out,
   output logic [dmbs_pkg::IDX_W-1:0]          rsp_selected_button,
   output logic                                rsp_highlight_change,
   output logic [dmbs_pkg::COORD_BITS-1:0]     rsp_hl_x_start,
   output logic [dmbs_pkg::COORD_BITS-1:0]     rsp_hl_x_end,
   output logic [dmbs_pkg::COORD_BITS-1:0]     rsp_hl_y_start,
   output logic [dmbs_pkg::COORD_BITS-1:0]     rsp_hl_y_end,
   output logic [dmbs_pkg::PAL_W-1:0]          rsp_hl_alpha
);
   import dmbs_pkg::*;

   localparam int unsigned AW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_BUTTONS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY_LINK,
      ST_KEY_TGT,
      ST_SCAN,
      ST_CLK_DONE
   } state_type;

   state_type            state_ff;
   logic [IDX_W-1:0]     current_ff;
   logic [IDX_W-1:0]     total_ff;
   logic [PAL_W-1:0]     palette_ff [PAL_SLOTS];
   logic [KEY_W-1:0]     key_ff;
   logic [IDX_W-1:0]     tgt_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic [IDX_W:0]       scan_ff;
   logic                 v1_ff;
   logic                 v2_ff;
   logic [IDX_W-1:0]     idx1_ff;
   logic [IDX_W-1:0]     idx2_ff;
   logic [IDX_W-1:0]     best_ff;
   logic [DIST_W-1:0]    best_dist_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_execute_ff;
   logic [ACTION_W-1:0]  rsp_command_ff;
   logic [IDX_W-1:0]     rsp_selected_ff;
   logic                 rsp_hl_change_ff;
   rect_type             rsp_rect_ff;
   logic [PAL_W-1:0]     rsp_alpha_ff;

   entry_type            table_mem [MAX_BUTTONS];
   entry_type            rd_ff;
   entry_type            wr_entry;
   logic [IDX_W-1:0]     rd_idx;
   logic [IDX_W-1:0]     rd_idx_m1;
   logic [IDX_W-1:0]     wr_idx_m1;
   logic                 wr_en;

   logic                 accept;
   logic                 cur_ok;
   logic [IDX_W-1:0]     link_tgt;
   logic                 tgt_ok;
   logic                 scan_done;
   logic                 hit;
   logic [DIST_W-1:0]    dist_sq;
   logic [PAL_W-1:0]     sel_pal;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Pick the neighbour named by the key from the current button's links
   always_comb begin
      unique case (key_ff)
         KEY_LEFT:  link_tgt = rd_ff.links[17:12];
         KEY_RIGHT: link_tgt = rd_ff.links[23:18];
         KEY_UP:    link_tgt = rd_ff.links[5:0];
         KEY_DOWN:  link_tgt = rd_ff.links[11:6];
         default:   link_tgt = '0;
      endcase
   end

   assign cur_ok    = (current_ff != '0) && (current_ff <= total_ff);
   assign tgt_ok    = (link_tgt != '0) && (link_tgt <= total_ff);
   assign scan_done = (scan_ff > {1'b0, total_ff});

   // Select the table read address (button numbers are 1-based)
   always_comb begin
      unique case (state_ff)
         ST_KEY_LINK: rd_idx = link_tgt;
         ST_SCAN:     rd_idx = scan_done ? best_ff : scan_ff[IDX_W-1:0];
         default:     rd_idx = current_ff;
      endcase
      rd_idx_m1 = rd_idx - IDX_W'(1);
      wr_idx_m1 = req_index - IDX_W'(1);
   end

   // Build the table entry for a button load
   always_comb begin
      wr_entry.rect     = unpack_geometry(req_raw_geometry);
      wr_entry.links    = req_links;
      wr_entry.action   = req_action_word;
      wr_entry.color    = req_color_set;
      wr_entry.auto_act = req_auto_action;
      wr_en = accept && (req_command == CMD_LOAD_BUTTON) &&
              (req_index != '0) && (req_index <= MAX_IDX);
   end

   // Button table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_idx_m1[AW-1:0]] <= wr_entry;
      end
      rd_ff <= table_mem[rd_idx_m1[AW-1:0]];
   end

   // Shared containment and distance unit
   dmbs_hit_unit u_hit (
      .clock   (clock),
      .rect    (rd_ff.rect),
      .pos_x   (x_ff),
      .pos_y   (y_ff),
      .hit     (hit),
      .dist_sq (dist_sq)
   );

   // Palette of the chosen button's colour set
   always_comb begin
      if (rd_ff.color == 2'd0) begin
         sel_pal = '0;
      end else begin
         sel_pal = palette_ff[rd_ff.color - 2'd1];
      end
   end

   // Sequencer, state and registered results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         current_ff   <= IDX_W'(1);
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         v2_ff        <= v1_ff;
         idx2_ff      <= idx1_ff;
         v1_ff        <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  key_ff       <= req_key;
                  x_ff         <= req_pos_x;
                  y_ff         <= req_pos_y;
                  scan_ff      <= (IDX_W + 1)'(1);
                  best_ff      <= '0;
                  best_dist_ff <= FAR_DIST;
                  unique case (req_command)
                     CMD_LOAD_PALETTE: begin
                        if ((req_index != '0) && (req_index <= IDX_W'(PAL_SLOTS))) begin
                           palette_ff[req_index[1:0] - 2'd1] <= req_palette_word;
                        end
                     end
                     CMD_SET_COUNT: begin
                        total_ff <= (req_index > MAX_IDX) ? MAX_IDX : req_index;
                     end
                     CMD_KEY:   state_ff <= ST_KEY_LINK;
                     CMD_CLICK: state_ff <= ST_SCAN;
                     default: ;
                  endcase
               end
            end

            // rd_ff holds the current button's entry
            ST_KEY_LINK: begin
               rsp_hl_change_ff <= 1'b0;
               rsp_rect_ff      <= '0;
               rsp_alpha_ff     <= '0;
               if (cur_ok && (key_ff <= KEY_DOWN) && tgt_ok) begin
                  tgt_ff   <= link_tgt;
                  state_ff <= ST_KEY_TGT;
               end else begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_selected_ff <= current_ff;
                  state_ff        <= ST_IDLE;
                  if (cur_ok && (key_ff == KEY_OK)) begin
                     rsp_execute_ff <= 1'b1;
                     rsp_command_ff <= rd_ff.action;
                  end else begin
                     rsp_execute_ff <= 1'b0;
                     rsp_command_ff <= '0;
                  end
               end
            end

            // rd_ff holds the linked button's entry
            ST_KEY_TGT: begin
               rsp_hl_change_ff <= 1'b0;
               rsp_rect_ff      <= '0;
               rsp_alpha_ff     <= '0;
               current_ff       <= tgt_ff;
               rsp_valid_ff     <= 1'b1;
               rsp_selected_ff  <= tgt_ff;
               rsp_execute_ff   <= rd_ff.auto_act;
               rsp_command_ff   <= rd_ff.auto_act ? rd_ff.action : '0;
               state_ff         <= ST_IDLE;
            end

            // Walk the buttons one per cycle; keep the first closest hit
            ST_SCAN: begin
               if (!scan_done) begin
                  v1_ff   <= 1'b1;
                  idx1_ff <= scan_ff[IDX_W-1:0];
                  scan_ff <= scan_ff + (IDX_W + 1)'(1);
               end
               if (v2_ff && hit && (dist_sq < best_dist_ff)) begin
                  best_ff      <= idx2_ff;
                  best_dist_ff <= dist_sq;
               end
               if (scan_done && !v1_ff && !v2_ff) begin
                  state_ff <= ST_CLK_DONE;
               end
            end

            // rd_ff holds the winning button's entry
            ST_CLK_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
               if (best_ff != '0) begin
                  current_ff      <= best_ff;
                  rsp_selected_ff <= best_ff;
                  rsp_execute_ff  <= 1'b1;
                  rsp_command_ff  <= rd_ff.action;
                  if (best_ff != current_ff) begin
                     rsp_hl_change_ff <= 1'b1;
                     rsp_rect_ff      <= rd_ff.rect;
                     rsp_alpha_ff     <= alpha_of(sel_pal);
                  end else begin
                     rsp_hl_change_ff <= 1'b0;
                     rsp_rect_ff      <= '0;
                     rsp_alpha_ff     <= '0;
                  end
               end else begin
                  rsp_selected_ff  <= current_ff;
                  rsp_execute_ff   <= 1'b0;
                  rsp_command_ff   <= '0;
                  rsp_hl_change_ff <= 1'b0;
                  rsp_rect_ff      <= '0;
                  rsp_alpha_ff     <= '0;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_execute          = rsp_execute_ff;
   assign rsp_command_out      = rsp_command_ff;
   assign rsp_selected_button  = rsp_selected_ff;
   assign rsp_highlight_change = rsp_hl_change_ff;
   assign rsp_hl_x_start       = rsp_rect_ff.x_start;
   assign rsp_hl_x_end         = rsp_rect_ff.x_end;
   assign rsp_hl_y_start       = rsp_rect_ff.y_start;
   assign rsp_hl_y_end         = rsp_rect_ff.y_end;
   assign rsp_hl_alpha         = rsp_alpha_ff;

   // A result only ends a transaction that kept the block busy
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a transaction in progress");

   // A new highlight comes only with a command to run
   a_hl_with_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_highlight_change |-> rsp_execute)
      else $error("highlight reported without execute");

   // The reported button is always a real button number
   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_selected_button != '0) && (rsp_selected_button <= MAX_IDX))
      else $error("selected button out of range");

   // Table, palette and count loads complete at acceptance
   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req_command == CMD_LOAD_BUTTON || req_command == CMD_LOAD_PALETTE ||
                 req_command == CMD_SET_COUNT) |=> !busy && !rsp_valid)
      else $error("load transaction kept the block busy");

endmodule

[hw/rtl/dmbs_hit_unit.sv]
module dmbs_hit_unit (
   input  logic                                clock,
   input  dmbs_pkg::rect_type                  rect,
   input  logic [dmbs_pkg::COORD_BITS-1:0]     pos_x,
   input  logic [dmbs_pkg::COORD_BITS-1:0]     pos_y,
   output logic                                hit,
   output logic [dmbs_pkg::DIST_W-1:0]         dist_sq
);
   import dmbs_pkg::*;

   localparam int unsigned DW = COORD_BITS + 1;

   logic                  inside_in;
   logic [COORD_BITS:0]   sum_x;
   logic [COORD_BITS:0]   sum_y;
   logic signed [DW-1:0]  dx_in;
   logic signed [DW-1:0]  dy_in;
   logic                  hit_ff;
   logic signed [DW-1:0]  dx_ff;
   logic signed [DW-1:0]  dy_ff;
   logic signed [2*DW-1:0] sq_x;
   logic signed [2*DW-1:0] sq_y;

   // Test containment and take offsets from the button centre
   always_comb begin
      inside_in = (pos_x >= rect.x_start) && (pos_x <= rect.x_end) &&
                  (pos_y >= rect.y_start) && (pos_y <= rect.y_end);
      sum_x = {1'b0, rect.x_start} + {1'b0, rect.x_end};
      sum_y = {1'b0, rect.y_start} + {1'b0, rect.y_end};
      dx_in = $signed({1'b0, sum_x[COORD_BITS:1]}) - $signed({1'b0, pos_x});
      dy_in = $signed({1'b0, sum_y[COORD_BITS:1]}) - $signed({1'b0, pos_y});
   end

   // Hold offsets for the squaring stage
   always_ff @(posedge clock) begin
      hit_ff <= inside_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
   end

   // Square and sum; both squares are non-negative
   always_comb begin
      sq_x    = dx_ff * dx_ff;
      sq_y    = dy_ff * dy_ff;
      dist_sq = DIST_W'($unsigned(sq_x)) + DIST_W'($unsigned(sq_y));
   end

   assign hit = hit_ff;

endmodule

[verif/tb_dvd_menu_button_select_unit.sv]
`timescale 1ns / 100ps

module tb_dvd_menu_button_select_unit;
   import dmbs_pkg::*;

   localparam int NBTN        = MAX_BUTTONS_DEF;
   localparam int ITEM_TARGET = 2000;
   localparam int MAX_REPORTS = 100;

   typedef struct packed {
      logic [CMD_W-1:0]      command;
      logic [IDX_W-1:0]      index;
      logic [GEOM_W-1:0]     raw_geometry;
      logic [1:0]            color_set;
      logic                  auto_action;
      logic [LINK_W-1:0]     links;
      logic [ACTION_W-1:0]   action_word;
      logic [PAL_W-1:0]      palette_word;
      logic [KEY_W-1:0]      key;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
   } menu_event_type;

   typedef struct packed {
      logic                  execute;
      logic [ACTION_W-1:0]   command_out;
      logic [IDX_W-1:0]      selected_button;
      logic                  highlight_change;
      logic [COORD_BITS-1:0] hl_x_start;
      logic [COORD_BITS-1:0] hl_x_end;
      logic [COORD_BITS-1:0] hl_y_start;
      logic [COORD_BITS-1:0] hl_y_end;
      logic [PAL_W-1:0]      hl_alpha;
   } menu_outcome_type;

   // Menu state mirror and queue of the outcomes still to arrive
   class select_scoreboard;
      rect_type            btn_rect[NBTN];
      logic [LINK_W-1:0]   btn_links[NBTN];
      logic [ACTION_W-1:0] btn_action[NBTN];
      logic [1:0]          btn_color[NBTN];
      logic                btn_auto[NBTN];
      logic [PAL_W-1:0]    sel_palette[PAL_SLOTS];
      int                  button_count;
      int                  current_button;
      int                  errors;
      menu_outcome_type    outcome_q[$];

      function new();
         button_count   = 0;
         current_button = 1;
         errors         = 0;
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      // Work out the outcome of one accepted transaction and update the mirror
      function void note_event(input menu_event_type ev);
         menu_outcome_type o;
         logic [7:0]    gb[6];
         logic [3:0]    nib;
         logic [1:0]    cs;
         logic [PAL_W-1:0] pal;
         int i, nb, tgt, x, y, x0, x1, y0, y1, dx, dy, d, near_d, best, prev;
         logic          steer;
         o     = '0;
         tgt   = 0;
         steer = 1'b0;
         case (ev.command)
            CMD_LOAD_BUTTON: begin
               if (ev.index >= 1 && ev.index <= NBTN) begin
                  nb = ev.index - 1;
                  for (i = 0; i < 6; i++) gb[i] = ev.raw_geometry[GEOM_W-1-8*i -: 8];
                  btn_rect[nb].x_start = {gb[0][5:0], gb[1][7:4]};
                  btn_rect[nb].x_end   = {gb[1][1:0], gb[2]};
                  btn_rect[nb].y_start = {gb[3][5:0], gb[4][7:4]};
                  btn_rect[nb].y_end   = {gb[4][1:0], gb[5]};
                  btn_color[nb]  = ev.color_set;
                  btn_auto[nb]   = ev.auto_action;
                  btn_links[nb]  = ev.links;
                  btn_action[nb] = ev.action_word;
               end
            end
            CMD_LOAD_PALETTE: begin
               if (ev.index >= 1 && ev.index <= PAL_SLOTS) sel_palette[ev.index-1] = ev.palette_word;
            end
            CMD_SET_COUNT: begin
               button_count = (ev.index > NBTN) ? NBTN : int'(ev.index);
            end
            CMD_KEY: begin
               if (current_button >= 1 && current_button <= button_count) begin
                  case (ev.key)
                     KEY_LEFT:  begin steer = 1'b1; tgt = btn_links[current_button-1][17:12]; end
                     KEY_RIGHT: begin steer = 1'b1; tgt = btn_links[current_button-1][23:18]; end
                     KEY_UP:    begin steer = 1'b1; tgt = btn_links[current_button-1][5:0];   end
                     KEY_DOWN:  begin steer = 1'b1; tgt = btn_links[current_button-1][11:6];  end
                     KEY_OK: begin
                        o.execute     = 1'b1;
                        o.command_out = btn_action[current_button-1];
                     end
                     default: ;
                  endcase
                  // Follow the link only when it names a valid button
                  if (steer && tgt >= 1 && tgt <= button_count) begin
                     current_button = tgt;
                     if (btn_auto[tgt-1]) begin
                        o.execute     = 1'b1;
                        o.command_out = btn_action[tgt-1];
                     end
                  end
               end
               o.selected_button = IDX_W'(current_button);
               outcome_q.push_back(o);
            end
            CMD_CLICK: begin
               x      = ev.pos_x;
               y      = ev.pos_y;
               near_d = int'(FAR_DIST);
               best   = 0;
               // Keep the containing button with the nearest centre; lower number wins ties
               for (i = 1; i <= button_count; i++) begin
                  x0 = btn_rect[i-1].x_start;
                  x1 = btn_rect[i-1].x_end;
                  y0 = btn_rect[i-1].y_start;
                  y1 = btn_rect[i-1].y_end;
                  if (x >= x0 && x <= x1 && y >= y0 && y <= y1) begin
                     dx = (x0 + x1) / 2 - x;
                     dy = (y0 + y1) / 2 - y;
                     d  = dx * dx + dy * dy;
                     if (d < near_d) begin
                        near_d = d;
                        best   = i;
                     end
                  end
               end
               if (best != 0) begin
                  prev           = current_button;
                  current_button = best;
                  o.execute      = 1'b1;
                  o.command_out  = btn_action[best-1];
                  if (best != prev) begin
                     cs  = btn_color[best-1];
                     pal = (cs == 2'd0) ? '0 : sel_palette[cs-1];
                     o.highlight_change = 1'b1;
                     o.hl_x_start = btn_rect[best-1].x_start;
                     o.hl_x_end   = btn_rect[best-1].x_end;
                     o.hl_y_start = btn_rect[best-1].y_start;
                     o.hl_y_end   = btn_rect[best-1].y_end;
                     for (i = 0; i < 4; i++) begin
                        nib = pal[4*i +: 4];
                        o.hl_alpha[8*i +: 8] = (nib == 4'hf) ? 8'hff : {nib, 4'h0};
                     end
                  end
               end
               o.selected_button = IDX_W'(current_button);
               outcome_q.push_back(o);
            end
            default: ;
         endcase
      endfunction

      function void check_field(input string name, input logic [63:0] want,
                                input logic [63:0] seen);
         if (want !== seen) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
         end
      endfunction

      // Compare one result with the oldest outstanding outcome
      function void check_outcome(input menu_outcome_type got);
         menu_outcome_type want;
         if (outcome_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) $error("result with no transaction outstanding");
         end else begin
            want = outcome_q.pop_front();
            check_field("execute",          want.execute,          got.execute);
            check_field("command_out",      want.command_out,      got.command_out);
            check_field("selected_button",  want.selected_button,  got.selected_button);
            check_field("highlight_change", want.highlight_change, got.highlight_change);
            check_field("hl_x_start",       want.hl_x_start,       got.hl_x_start);
            check_field("hl_x_end",         want.hl_x_end,         got.hl_x_end);
            check_field("hl_y_start",       want.hl_y_start,       got.hl_y_start);
            check_field("hl_y_end",         want.hl_y_end,         got.hl_y_end);
            check_field("hl_alpha",         want.hl_alpha,         got.hl_alpha);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  start            = 1'b0;
   logic                  busy;
   logic [CMD_W-1:0]      req_command      = '0;
   logic [IDX_W-1:0]      req_index        = '0;
   logic [GEOM_W-1:0]     req_raw_geometry = '0;
   logic [1:0]            req_color_set    = '0;
   logic                  req_auto_action  = 1'b0;
   logic [LINK_W-1:0]     req_links        = '0;
   logic [ACTION_W-1:0]   req_action_word  = '0;
   logic [PAL_W-1:0]      req_palette_word = '0;
   logic [KEY_W-1:0]      req_key          = '0;
   logic [COORD_BITS-1:0] req_pos_x        = '0;
   logic [COORD_BITS-1:0] req_pos_y        = '0;
   logic                  rsp_valid;
   logic                  rsp_execute;
   logic [ACTION_W-1:0]   rsp_command_out;
   logic [IDX_W-1:0]      rsp_selected_button;
   logic                  rsp_highlight_change;
   logic [COORD_BITS-1:0] rsp_hl_x_start;
   logic [COORD_BITS-1:0] rsp_hl_x_end;
   logic [COORD_BITS-1:0] rsp_hl_y_start;
   logic [COORD_BITS-1:0] rsp_hl_y_end;
   logic [PAL_W-1:0]      rsp_hl_alpha;

   select_scoreboard sb;
   bit               written[NBTN];
   int               idle_pct    = 0;
   int               sent_items  = 0;

   dvd_menu_button_select_unit u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_command          (req_command),
      .req_index            (req_index),
      .req_raw_geometry     (req_raw_geometry),
      .req_color_set        (req_color_set),
      .req_auto_action      (req_auto_action),
      .req_links            (req_links),
      .req_action_word      (req_action_word),
      .req_palette_word     (req_palette_word),
      .req_key              (req_key),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .rsp_valid            (rsp_valid),
      .rsp_execute          (rsp_execute),
      .rsp_command_out      (rsp_command_out),
      .rsp_selected_button  (rsp_selected_button),
      .rsp_highlight_change (rsp_highlight_change),
      .rsp_hl_x_start       (rsp_hl_x_start),
      .rsp_hl_x_end         (rsp_hl_x_end),
      .rsp_hl_y_start       (rsp_hl_y_start),
      .rsp_hl_y_end         (rsp_hl_y_end),
      .rsp_hl_alpha         (rsp_hl_alpha)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Sample accepted transactions and results at the clock edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && busy === 1'b0)
            sb.note_event('{req_command, req_index, req_raw_geometry, req_color_set,
                            req_auto_action, req_links, req_action_word, req_palette_word,
                            req_key, req_pos_x, req_pos_y});
         if (rsp_valid === 1'b1)
            sb.check_outcome('{rsp_execute, rsp_command_out, rsp_selected_button,
                               rsp_highlight_change, rsp_hl_x_start, rsp_hl_x_end,
                               rsp_hl_y_start, rsp_hl_y_end, rsp_hl_alpha});
      end
   end

   // Random filler in every field, command as given
   function automatic menu_event_type make_event(input logic [CMD_W-1:0] cmd);
      menu_event_type ev;
      ev.command      = cmd;
      ev.index        = IDX_W'($urandom());
      ev.raw_geometry = {16'($urandom()), $urandom()};
      ev.color_set    = 2'($urandom());
      ev.auto_action  = 1'($urandom());
      ev.links        = LINK_W'($urandom());
      ev.action_word  = {$urandom(), $urandom()};
      ev.palette_word = $urandom();
      ev.key          = KEY_W'($urandom());
      ev.pos_x        = COORD_BITS'($urandom());
      ev.pos_y        = COORD_BITS'($urandom());
      return ev;
   endfunction

   // Pack the rectangle into the six coordinate bytes; unused bits stay random
   function automatic menu_event_type button_event(input int idx, input int x0, input int x1,
                                                   input int y0, input int y1,
                                                   input logic [1:0] color,
                                                   input logic auto_act,
                                                   input logic [LINK_W-1:0] lk,
                                                   input logic [ACTION_W-1:0] action);
      menu_event_type        ev;
      logic [COORD_BITS-1:0] a, b, c, d;
      ev = make_event(CMD_LOAD_BUTTON);
      a  = COORD_BITS'(x0);
      b  = COORD_BITS'(x1);
      c  = COORD_BITS'(y0);
      d  = COORD_BITS'(y1);
      ev.index = IDX_W'(idx);
      ev.raw_geometry[45:36] = a;
      ev.raw_geometry[33:24] = b;
      ev.raw_geometry[21:12] = c;
      ev.raw_geometry[9:0]   = d;
      ev.color_set   = color;
      ev.auto_action = auto_act;
      ev.links       = lk;
      ev.action_word = action;
      return ev;
   endfunction

   function automatic menu_event_type key_event(input logic [KEY_W-1:0] k);
      menu_event_type ev;
      ev     = make_event(CMD_KEY);
      ev.key = k;
      return ev;
   endfunction

   function automatic menu_event_type click_event(input int x, input int y);
      menu_event_type ev;
      ev       = make_event(CMD_CLICK);
      ev.pos_x = COORD_BITS'(x);
      ev.pos_y = COORD_BITS'(y);
      return ev;
   endfunction

   // A random count that reads only written table entries
   function automatic int safe_count();
      int j;
      for (j = 0; j < NBTN; j++)
         if (!written[j]) return $urandom_range(0, j);
      return $urandom_range(0, (1 << IDX_W) - 1);
   endfunction

   // Mostly well-formed rectangles, some small, some raw noise
   function automatic menu_event_type random_button(input int idx, input int n);
      menu_event_type    ev;
      logic [LINK_W-1:0] lk;
      int x0, x1, y0, y1, w, f;
      for (f = 0; f < 4; f++)
         lk[6*f +: 6] = 6'(($urandom_range(0, 4) != 0) ? $urandom_range(1, n)
                                                        : $urandom_range(0, 63));
      x0 = $urandom_range(0, 1023);
      w  = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 150);
      x1 = (x0 + w > 1023) ? 1023 : x0 + w;
      y0 = $urandom_range(0, 1023);
      w  = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 150);
      y1 = (y0 + w > 1023) ? 1023 : y0 + w;
      ev = button_event(idx, x0, x1, y0, y1, 2'($urandom()), 1'($urandom()), lk,
                        {$urandom(), $urandom()});
      if ($urandom_range(0, 99) < 15) ev.raw_geometry = {16'($urandom()), $urandom()};
      return ev;
   endfunction

   // Clicks aimed mostly inside a live button, keys, and some noise
   function automatic menu_event_type random_event();
      menu_event_type ev;
      rect_type       r;
      int             pick, j;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         ev = make_event(CMD_W'($urandom()));
         if (ev.command == CMD_SET_COUNT) ev.index = IDX_W'(safe_count());
      end else if (pick < 55) begin
         if (sb.button_count > 0 && $urandom_range(0, 3) != 0) begin
            j  = $urandom_range(1, sb.button_count);
            r  = sb.btn_rect[j-1];
            ev = click_event($urandom_range(r.x_start, r.x_end),
                             $urandom_range(r.y_start, r.y_end));
         end else begin
            ev = click_event($urandom_range(0, 1023), $urandom_range(0, 1023));
         end
      end else begin
         ev = key_event(KEY_W'(($urandom_range(0, 4) == 0) ? $urandom_range(4, 7)
                                                           : $urandom_range(0, 3)));
      end
      return ev;
   endfunction

   // Present one transaction, hold it until accepted, then idle at random
   task automatic send_event(input menu_event_type ev);
      int gap;
      start            <= 1'b1;
      req_command      <= ev.command;
      req_index        <= ev.index;
      req_raw_geometry <= ev.raw_geometry;
      req_color_set    <= ev.color_set;
      req_auto_action  <= ev.auto_action;
      req_links        <= ev.links;
      req_action_word  <= ev.action_word;
      req_palette_word <= ev.palette_word;
      req_key          <= ev.key;
      req_pos_x        <= ev.pos_x;
      req_pos_y        <= ev.pos_y;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      if (ev.command == CMD_LOAD_BUTTON && ev.index >= 1 && ev.index <= NBTN)
         written[ev.index-1] = 1'b1;
      if (ev.command <= CMD_CLICK) sent_items++;
      if ($urandom_range(0, 99) < idle_pct) begin
         gap   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 45) : $urandom_range(1, 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Load random palettes and a menu of n buttons, set the count, then navigate it
   task automatic build_menu(input int n);
      menu_event_type ev;
      int j, k;
      for (j = 1; j <= PAL_SLOTS; j++) begin
         if ($urandom_range(0, 1)) begin
            ev       = make_event(CMD_LOAD_PALETTE);
            ev.index = IDX_W'(j);
            send_event(ev);
         end
      end
      for (j = 1; j <= n; j++) send_event(random_button(j, n));
      ev       = make_event(CMD_SET_COUNT);
      ev.index = IDX_W'(n);
      send_event(ev);
      k = $urandom_range(8, 30);
      for (j = 0; j < k; j++) send_event(random_event());
   endtask

   initial begin
      menu_event_type ev;
      int             phase, phase_end, waited, n;
      bit             first_menu;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Events with no valid current button and an empty table
      send_event(key_event(KEY_OK));
      send_event(click_event(512, 512));

      // Palettes, including an out-of-range slot
      ev = make_event(CMD_LOAD_PALETTE); ev.index = '0; send_event(ev);
      ev.index = IDX_W'(1); ev.palette_word = 32'h0000_F0A5; send_event(ev);
      ev.index = IDX_W'(2); ev.palette_word = 32'hFFFF_FFFF; send_event(ev);
      ev.index = IDX_W'(3); ev.palette_word = 32'h0000_0000; send_event(ev);

      // Out-of-range button loads
      send_event(button_event(0,  0, 1023, 0, 1023, 2'd1, 1'b1, '1, '1));
      send_event(button_event(37, 0, 1023, 0, 1023, 2'd1, 1'b1, '1, '1));
      send_event(button_event(63, 0, 1023, 0, 1023, 2'd1, 1'b1, '1, '1));

      // Full-width button 1; buttons 2 and 3 share one rectangle to force a tie
      send_event(button_event(1, 0, 1023, 0, 1022, 2'd3, 1'b1,
                              {6'd2, 6'd0, 6'd3, 6'd63}, 64'hFFFF_FFFF_FFFF_FFFF));
      send_event(button_event(2, 100, 300, 100, 300, 2'd1, 1'b0,
                              {6'd0, 6'd1, 6'd0, 6'd0}, 64'h0123_4567_89AB_CDEF));
      send_event(button_event(3, 100, 300, 100, 300, 2'd2, 1'b1,
                              {6'd1, 6'd2, 6'd1, 6'd2}, 64'h0));
      ev = make_event(CMD_SET_COUNT); ev.index = IDX_W'(3); send_event(ev);

      // Invalid links, a non-auto move, auto moves, OK, and the keys that do nothing
      send_event(key_event(KEY_LEFT));
      send_event(key_event(KEY_UP));
      send_event(key_event(KEY_RIGHT));
      send_event(key_event(KEY_LEFT));
      send_event(key_event(KEY_DOWN));
      send_event(key_event(KEY_OK));
      send_event(key_event(3'd5));
      send_event(key_event(3'd7));

      // Tie, repeated click without a highlight change, a miss, and the corners
      send_event(click_event(200, 200));
      send_event(click_event(200, 200));
      send_event(click_event(1023, 1023));
      send_event(click_event(1023, 1022));
      send_event(click_event(0, 0));

      // Unused command codes
      send_event(make_event(3'd5));
      send_event(make_event(3'd7));

      // Random menus: sender idles rarely, then often, then never
      first_menu = 1'b1;
      for (phase = 0; phase < 3; phase++) begin
         idle_pct  = (phase == 0) ? 23 : (phase == 1) ? 87 : 0;
         phase_end = sent_items + ITEM_TARGET / 3;
         while (sent_items < phase_end) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, NBTN) : $urandom_range(1, 8);
            if (first_menu) n = NBTN;
            first_menu = 1'b0;
            build_menu(n);
         end
      end
      start <= 1'b0;

      // Drain outstanding results, then give stray results time to show
      waited = 0;
      while (sb.pending() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (60) @(posedge clock);
      if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb_dvd_menu_button_select_unit: clean");
      else
         $display("tb_dvd_menu_button_select_unit: errors");
      $finish;
   end

   // Watchdog
   initial begin
      #(20_000_000);
      $display("tb_dvd_menu_button_select_unit: errors");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/dmbs_pkg.sv
hw/rtl/dmbs_hit_unit.sv
hw/rtl/dvd_menu_button_select_unit.sv
verif/tb_dvd_menu_button_select_unit.sv
